>>> hw/rtl/rsc_pkg.sv
package rsc_pkg;

    localparam int DATA_W        = 16;
    localparam int GRANT_LIMIT   = 8;
    localparam int MASK_W        = 8;
    localparam int ACC_W         = DATA_W + $clog2(GRANT_LIMIT) + 2;
    localparam int NP_W          = 4;
    localparam int NR_W          = 5;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int DEF_NUM_PROCS = 8;
    localparam int DEF_NUM_RES   = 4;

    // register select is paddr bit 2
    localparam logic REG_PROCS = 1'b0;
    localparam logic REG_RES   = 1'b1;

    typedef enum logic [1:0] {
        OP_TOTAL = 2'd0,
        OP_CLAIM = 2'd1,
        OP_CHECK = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_GRANT   = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    localparam logic [1:0] CODE_OK         = 2'd0;
    localparam logic [1:0] CODE_CLAIM_OVER = 2'd1;
    localparam logic [1:0] CODE_ALLOC_OVER = 2'd2;
    localparam logic [1:0] CODE_SAFE       = 2'd0;
    localparam logic [1:0] CODE_UNSAFE     = 2'd1;
    localparam logic [1:0] CODE_OVERCOMMIT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_AV_ROW,
        ST_AV_RD,
        ST_AV_ACC,
        ST_SC_TEST,
        ST_SC_RD,
        ST_SC_CMP,
        ST_GR_RD,
        ST_GR_ADD,
        ST_GR_EMIT,
        ST_VERDICT
    } state_t;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        logic [ACC_W-1:0]  res;   // two's complement
        logic              fits;  // claim <= res
        logic [DATA_W-1:0] sat;   // res saturated at the DATA_W maximum
    } alu_out_t;

    typedef struct packed {
        logic [NP_W-1:0] np;
        logic [NR_W-1:0] nr;
    } cfg_t;

endpackage

>>> hw/rtl/rsc_ram.sv
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/rsc_alu.sv
module rsc_alu (
    input  rsc_pkg::alu_op_t                 op,
    input  logic [rsc_pkg::ACC_W-1:0]        x,
    input  logic [rsc_pkg::DATA_W-1:0]       y,
    input  logic [rsc_pkg::DATA_W-1:0]       claim,
    output rsc_pkg::alu_out_t                res
);
    import rsc_pkg::*;

    logic signed [ACC_W-1:0] xs;
    logic signed [ACC_W-1:0] ys;
    logic signed [ACC_W-1:0] cs;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sat_max;

    assign xs      = signed'(x);
    assign ys      = signed'(ACC_W'(y));
    assign cs      = signed'(ACC_W'(claim));
    assign sat_max = signed'(ACC_W'({DATA_W{1'b1}}));
    assign sum     = (op == ALU_SUB) ? (xs - ys) : (xs + ys);

    assign res.res  = unsigned'(sum);
    assign res.fits = (cs <= sum);
    assign res.sat  = (sum > sat_max) ? {DATA_W{1'b1}} : sum[DATA_W-1:0];

endmodule

>>> hw/rtl/rsc_cfg.sv
module rsc_cfg #(
    parameter int NUM_PROCS = rsc_pkg::DEF_NUM_PROCS,
    parameter int NUM_RES   = rsc_pkg::DEF_NUM_RES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output rsc_pkg::cfg_t                 cfg
);
    import rsc_pkg::*;

    localparam int NP_LIM = (NUM_PROCS < GRANT_LIMIT) ? NUM_PROCS : GRANT_LIMIT;

    logic [3:0] procs_reg;
    logic [2:0] res_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            procs_reg <= 4'd8;
            res_reg   <= 3'd4;
        end else if (wr_en) begin
            if (paddr[2] == REG_PROCS) begin
                procs_reg <= pwdata[3:0];
            end else begin
                res_reg <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RES) ? PDATA_W'(res_reg) : PDATA_W'(procs_reg);

    // effective counts: clamp to the build limits, zero counts as one
    always_comb begin
        if (procs_reg == 4'd0) begin
            cfg.np = NP_W'(1);
        end else if (32'(procs_reg) > NP_LIM) begin
            cfg.np = NP_W'(NP_LIM);
        end else begin
            cfg.np = NP_W'(procs_reg);
        end
        if (res_reg == 3'd0) begin
            cfg.nr = NR_W'(1);
        end else if (32'(res_reg) > NUM_RES) begin
            cfg.nr = NR_W'(NUM_RES);
        end else begin
            cfg.nr = NR_W'(res_reg);
        end
    end

endmodule

>>> hw/rtl/resource_safety_checker_unit.sv
// Banker's algorithm safety checker. Input items either load a resource
// total (opcode 0), load one process/resource claim and allocation pair
// (opcode 1), or run a safety check (opcode 2); opcode 3 is dropped with no
// result. Each load gets one acknowledge item with a status. A check first
// forms available = total minus allocations of the processes in use and
// returns a single overcommit verdict if any class goes negative; otherwise
// it returns one item per granted process in safe order and closes with a
// safe/unsafe verdict carrying last_result. The block handles one input
// item at a time: s_ready is high only while the sequencer is idle, and
// results leave through a one-item output register. A load is accepted,
// then acknowledged once the output register is free. A check runs on
// one claim/allocation RAM read port and one shared add/compare unit:
// an available pass over every class and process in use, then per grant
// a scan of the unfinished processes, a work vector update and an emit,
// so the worst case grows as np*np*nr, plus any output stall.
// procs_in_use (addr 0) and resources_in_use (addr 4) are set over APB
// and are clamped to the build limits, zero counting as one. The claim
// and allocation RAM comes up undefined and has no clearing pass.
module resource_safety_checker_unit #(
    parameter int NUM_PROCS = rsc_pkg::DEF_NUM_PROCS,
    parameter int NUM_RES   = rsc_pkg::DEF_NUM_RES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [2:0]                    s_proc_index,
    input  logic [1:0]                    s_res_index,
    input  logic [15:0]                   s_amount_value,
    input  logic [15:0]                   s_alloc_value,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_result_kind,
    output logic [2:0]                    m_granted_proc,
    output logic [1:0]                    m_result_code,
    output logic                          m_last_result,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import rsc_pkg::*;

    localparam int DEPTH = NUM_PROCS * NUM_RES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

    // flat table index of a process/resource pair
    function automatic logic [AW-1:0] pr_addr(input logic [NP_W-1:0] p,
                                              input logic [RW-1:0]   r);
        return AW'(p) * AW'(NUM_RES) + AW'(r);
    endfunction

    cfg_t cfg;

    rsc_cfg #(
        .NUM_PROCS (NUM_PROCS),
        .NUM_RES   (NUM_RES)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer state
    state_t              state_reg, state_next;
    logic [NP_W-1:0]     p_reg, p_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [MASK_W-1:0]   fin_reg, fin_next;
    logic [1:0]          verdict_reg, verdict_next;

    // latched input item
    logic [1:0]          op_reg;
    logic [2:0]          pi_reg;
    logic [1:0]          ri_reg;
    logic [DATA_W-1:0]   amt_reg;
    logic [DATA_W-1:0]   alc_reg;

    // small vectors in flops
    logic [DATA_W-1:0]   total_reg [NUM_RES];
    logic [DATA_W-1:0]   work_reg  [NUM_RES];
    logic                total_we;
    logic                work_we;
    logic                work_clr;
    logic [DATA_W-1:0]   work_wdata;
    logic [RW-1:0]       tot_idx;
    logic [DATA_W-1:0]   tot_rd;
    logic [DATA_W-1:0]   work_rd;

    // claim/allocation RAM: claim in the upper half, allocation in the lower
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [2*DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0]   rd_claim;
    logic [DATA_W-1:0]   rd_alloc;

    // shared unit
    alu_op_t             alu_op;
    logic [ACC_W-1:0]    alu_x;
    alu_out_t            alu_res;

    // output register
    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [2:0]          out_proc_reg;
    logic [1:0]          out_code_reg;
    logic                out_last_reg;
    logic                out_free;
    logic                out_load;
    kind_t               out_kind;
    logic [2:0]          out_proc;
    logic [1:0]          out_code;

    logic                accept;
    logic                r_last;
    logic                p_last;
    logic                pi_ok;
    logic                ri_ok;
    logic [MASK_W-1:0]   all_mask;

    rsc_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({amt_reg, alc_reg}),
        .rdata (ram_rdata)
    );

    assign rd_claim = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_alloc = ram_rdata[DATA_W-1:0];

    rsc_alu u_alu (
        .op    (alu_op),
        .x     (alu_x),
        .y     (rd_alloc),
        .claim (rd_claim),
        .res   (alu_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign tot_idx  = (state_reg == ST_LOAD) ? RW'(ri_reg) : r_reg;
    assign tot_rd   = total_reg[tot_idx];
    assign work_rd  = work_reg[r_reg];

    assign r_last   = ((NR_W'(r_reg) + NR_W'(1)) == cfg.nr);
    assign p_last   = ((p_reg + NP_W'(1)) == cfg.np);
    assign pi_ok    = (32'(pi_reg) < NUM_PROCS);
    assign ri_ok    = (32'(ri_reg) < NUM_RES);
    assign all_mask = MASK_W'((9'd1 << cfg.np) - 9'd1);

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        fin_next     = fin_reg;
        verdict_next = verdict_reg;
        ram_we       = 1'b0;
        ram_addr     = pr_addr(p_reg, r_reg);
        total_we     = 1'b0;
        work_we      = 1'b0;
        work_clr     = 1'b0;
        work_wdata   = alu_res.sat;
        out_load     = 1'b0;
        out_kind     = KIND_ACK;
        out_proc     = 3'd0;
        out_code     = CODE_OK;
        alu_op       = ALU_ADD;
        alu_x        = ACC_W'(work_rd);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_t'(s_opcode))
                        OP_TOTAL, OP_CLAIM: state_next = ST_LOAD;
                        OP_CHECK: begin
                            work_clr   = 1'b1;
                            fin_next   = '0;
                            r_next     = '0;
                            state_next = ST_AV_ROW;
                        end
                        OP_NOP:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                ram_addr = pr_addr(NP_W'(pi_reg), RW'(ri_reg));
                if (out_free) begin
                    out_load = 1'b1;
                    if (op_t'(op_reg) == OP_TOTAL) begin
                        total_we = ri_ok;
                    end else if (pi_ok && ri_ok) begin
                        // claim is tested against the total first
                        priority if (amt_reg > tot_rd) begin
                            out_code = CODE_CLAIM_OVER;
                        end else if (alc_reg > amt_reg) begin
                            out_code = CODE_ALLOC_OVER;
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_AV_ROW: begin
                acc_next   = ACC_W'(tot_rd);
                p_next     = '0;
                state_next = ST_AV_RD;
            end
            ST_AV_RD: begin
                state_next = ST_AV_ACC;
            end
            ST_AV_ACC: begin
                alu_op   = ALU_SUB;
                alu_x    = acc_reg;
                acc_next = alu_res.res;
                if (p_last) begin
                    if (alu_res.res[ACC_W-1]) begin
                        // overcommit ends the check at once
                        work_clr     = 1'b1;
                        fin_next     = '0;
                        verdict_next = CODE_OVERCOMMIT;
                        state_next   = ST_VERDICT;
                    end else begin
                        work_we    = 1'b1;
                        work_wdata = alu_res.res[DATA_W-1:0];
                        if (r_last) begin
                            p_next     = '0;
                            state_next = ST_SC_TEST;
                        end else begin
                            r_next     = r_reg + RW'(1);
                            state_next = ST_AV_ROW;
                        end
                    end
                end else begin
                    p_next     = p_reg + NP_W'(1);
                    state_next = ST_AV_RD;
                end
            end
            ST_SC_TEST: begin
                if (p_reg == cfg.np) begin
                    verdict_next = ((fin_reg & all_mask) == all_mask) ? CODE_SAFE
                                                                      : CODE_UNSAFE;
                    state_next   = ST_VERDICT;
                end else if (fin_reg[p_reg[2:0]]) begin
                    p_next = p_reg + NP_W'(1);
                end else begin
                    r_next     = '0;
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                state_next = ST_SC_CMP;
            end
            ST_SC_CMP: begin
                // need <= work  <=>  claim <= work + alloc
                if (!alu_res.fits) begin
                    p_next     = p_reg + NP_W'(1);
                    state_next = ST_SC_TEST;
                end else if (r_last) begin
                    r_next     = '0;
                    state_next = ST_GR_RD;
                end else begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_SC_RD;
                end
            end
            ST_GR_RD: begin
                state_next = ST_GR_ADD;
            end
            ST_GR_ADD: begin
                work_we = 1'b1;
                if (r_last) begin
                    fin_next[p_reg[2:0]] = 1'b1;
                    state_next           = ST_GR_EMIT;
                end else begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_GR_RD;
                end
            end
            ST_GR_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_GRANT;
                    out_proc   = p_reg[2:0];
                    p_next     = '0;
                    state_next = ST_SC_TEST;
                end
            end
            ST_VERDICT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_VERDICT;
                    out_code   = verdict_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        verdict_reg <= verdict_next;
        if (accept) begin
            op_reg  <= s_opcode;
            pi_reg  <= s_proc_index;
            ri_reg  <= s_res_index;
            amt_reg <= s_amount_value;
            alc_reg <= s_alloc_value;
        end
        if (out_load) begin
            out_kind_reg <= out_kind;
            out_proc_reg <= out_proc;
            out_code_reg <= out_code;
            out_last_reg <= (out_kind != KIND_GRANT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_RES; i++) begin
                total_reg[i] <= '0;
                work_reg[i]  <= '0;
            end
        end else begin
            if (total_we) begin
                total_reg[tot_idx] <= amt_reg;
            end
            if (work_clr) begin
                for (int i = 0; i < NUM_RES; i++) begin
                    work_reg[i] <= '0;
                end
            end else if (work_we) begin
                work_reg[r_reg] <= work_wdata;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_kind_reg;
    assign m_granted_proc = out_proc_reg;
    assign m_result_code  = out_code_reg;
    assign m_last_result  = out_last_reg;

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam int N_PROCS = DEF_NUM_PROCS;
    localparam int N_RES   = DEF_NUM_RES;

    // one input item as it sits on the s_ side
    typedef struct {
        op_t         op;
        logic [2:0]  proc;
        logic [1:0]  res;
        logic [15:0] amount;
        logic [15:0] alloc;
    } rsc_item_t;

    // one result item as it leaves on the m_ side
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] proc;
        logic [1:0] code;
        logic       last;
    } reply_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode       = '0;
    logic [2:0]  s_proc_index   = '0;
    logic [1:0]  s_res_index    = '0;
    logic [15:0] s_amount_value = '0;
    logic [15:0] s_alloc_value  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_result_kind;
    logic [2:0]  m_granted_proc;
    logic [1:0]  m_result_code;
    logic        m_last_result;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    resource_safety_checker_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_proc_index   (s_proc_index),
        .s_res_index    (s_res_index),
        .s_amount_value (s_amount_value),
        .s_alloc_value  (s_alloc_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_granted_proc (m_granted_proc),
        .m_result_code  (m_result_code),
        .m_last_result  (m_last_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Banker's state mirror: tables, work vector, finished mask, and the
    // two config registers as last written over APB.
    // ------------------------------------------------------------------
    bit [15:0] tot_units  [N_RES];
    bit [15:0] claim_mem  [N_PROCS*N_RES];
    bit [15:0] alloc_mem  [N_PROCS*N_RES];
    bit [15:0] work_units [N_RES];
    bit [7:0]  done_mask;
    bit [3:0]  procs_reg = 4'd8;
    bit [2:0]  res_reg   = 3'd4;

    rsc_item_t item_backlog [$];   // items waiting for the driver
    reply_t    safety_replies [$]; // results owed by the block, oldest first
    rsc_item_t cur_item;           // item currently offered on s_
    int        accepted_items;
    int        random_items;
    bit        count_random;
    int        mismatches;
    int        hold_left;
    bit        hold_done;

    // register values clamp to the build limits, zero means one
    function automatic int eff_procs();
        int n;
        n = procs_reg;
        if (n > N_PROCS) n = N_PROCS;
        if (n > GRANT_LIMIT) n = GRANT_LIMIT;
        if (n == 0) n = 1;
        return n;
    endfunction

    function automatic int eff_res();
        int n;
        n = res_reg;
        if (n > N_RES) n = N_RES;
        if (n == 0) n = 1;
        return n;
    endfunction

    // both sides run with no gaps over this window of accepted items
    function automatic bit quiet_stretch();
        return accepted_items >= 120 && accepted_items < 180;
    endfunction

    function automatic void owe_reply(logic [1:0] kind, int proc, logic [1:0] code,
                                      logic last);
        reply_t rp;
        rp.kind = kind;
        rp.proc = proc[2:0];
        rp.code = code;
        rp.last = last;
        safety_replies.push_back(rp);
    endfunction

    // Apply one accepted item to the mirror and queue the results it owes.
    task automatic bankers_predict(input rsc_item_t it);
        int np, nr, p, r, idx, sum;
        int avail [N_RES];
        bit short_fall, fits, progress;
        logic [1:0] code;
        bit [7:0] all_mask;
        np = eff_procs();
        nr = eff_res();
        case (it.op)
            OP_TOTAL: begin
                if (it.res < N_RES) tot_units[it.res] = it.amount;
                owe_reply(KIND_ACK, 0, CODE_OK, 1'b1);
            end
            OP_CLAIM: begin
                code = CODE_OK;
                if (it.proc < N_PROCS && it.res < N_RES) begin
                    idx = int'(it.proc) * N_RES + int'(it.res);
                    // claim is tested against the total first
                    if (it.amount > tot_units[it.res]) begin
                        code = CODE_CLAIM_OVER;
                    end else if (it.alloc > it.amount) begin
                        code = CODE_ALLOC_OVER;
                    end else begin
                        claim_mem[idx] = it.amount;
                        alloc_mem[idx] = it.alloc;
                    end
                end
                owe_reply(KIND_ACK, 0, code, 1'b1);
            end
            OP_CHECK: begin
                short_fall = 1'b0;
                for (r = 0; r < nr; r++) begin
                    avail[r] = int'(tot_units[r]);
                    for (p = 0; p < np; p++) avail[r] -= int'(alloc_mem[p*N_RES + r]);
                    if (avail[r] < 0) short_fall = 1'b1;
                end
                for (r = 0; r < N_RES; r++) work_units[r] = '0;
                done_mask = '0;
                if (short_fall) begin
                    owe_reply(KIND_VERDICT, 0, CODE_OVERCOMMIT, 1'b1);
                end else begin
                    for (r = 0; r < nr; r++) work_units[r] = avail[r][15:0];
                    // grant the lowest unfinished process that fits, then rescan
                    progress = 1'b1;
                    while (progress) begin
                        progress = 1'b0;
                        for (p = 0; p < np && !progress; p++) begin
                            if (!done_mask[p]) begin
                                fits = 1'b1;
                                for (r = 0; r < nr; r++) begin
                                    idx = p*N_RES + r;
                                    if (int'(claim_mem[idx]) - int'(alloc_mem[idx])
                                        > int'(work_units[r]))
                                        fits = 1'b0;
                                end
                                if (fits) begin
                                    for (r = 0; r < nr; r++) begin
                                        sum = int'(work_units[r]) + int'(alloc_mem[p*N_RES + r]);
                                        work_units[r] = (sum > 65535) ? 16'hFFFF : sum[15:0];
                                    end
                                    done_mask[p] = 1'b1;
                                    owe_reply(KIND_GRANT, p, CODE_OK, 1'b0);
                                    progress = 1'b1;
                                end
                            end
                        end
                    end
                    all_mask = 8'((9'd1 << np) - 9'd1);
                    owe_reply(KIND_VERDICT, 0,
                              ((done_mask & all_mask) == all_mask) ? CODE_SAFE : CODE_UNSAFE,
                              1'b1);
                end
            end
            default: ;  // opcode three: dropped, nothing owed
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offers items from the backlog, holds them until accepted,
    // idles now and then. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bankers_predict(cur_item);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (item_backlog.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= 15)) begin
                    cur_item = item_backlog.pop_front();
                    s_valid        <= 1'b1;
                    s_opcode       <= cur_item.op;
                    s_proc_index   <= cur_item.proc;
                    s_res_index    <= cur_item.res;
                    s_amount_value <= cur_item.amount;
                    s_alloc_value  <= cur_item.alloc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold-off once the backlog
    // is deep so the block fills and drops s_ready, and result checking.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t want, got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && accepted_items >= 40 && item_backlog.size() >= 8) begin
                hold_done = 1'b1;
                hold_left = 200;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_stretch() || ($urandom_range(0, 99) >= 15);
            end

            if (m_valid && m_ready) begin
                got = {m_result_kind, m_granted_proc, m_result_code, m_last_result};
                if (safety_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none owed: kind %0d proc %0d code %0d last %0d",
                             $time, got.kind, got.proc, got.code, got.last);
                end else begin
                    want = safety_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected kind %0d proc %0d code %0d last %0d",
                                 $time, want.kind, want.proc, want.code, want.last);
                        $display("%0t:                  actual kind %0d proc %0d code %0d last %0d",
                                 $time, got.kind, got.proc, got.code, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input op_t op, input int p, input int r,
                              input int amt, input int alc);
        rsc_item_t it;
        it.op     = op;
        it.proc   = p[2:0];
        it.res    = r[1:0];
        it.amount = amt[15:0];
        it.alloc  = alc[15:0];
        item_backlog.push_back(it);
        if (count_random && op != OP_NOP) random_items++;
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_PROCS) procs_reg = value[3:0];
        else res_reg = value[2:0];
    endtask

    // all items taken and answered, plus slack for a dropped opcode
    task automatic wait_idle();
        do @(posedge aclk);
        while (item_backlog.size() != 0 || s_valid || safety_replies.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    // One well-formed scenario: totals, every in-use pair rewritten, then
    // a check. Broken claim loads and noise are mixed in along the way.
    task automatic queue_scenario();
        int np, nr, p, r, style, cmode, share, a, c;
        int tot [N_RES];
        np    = eff_procs();
        nr    = eff_res();
        style = $urandom_range(0, 3);
        cmode = $urandom_range(0, 2);
        for (r = 0; r < nr; r++) begin
            case (style)
                0:       tot[r] = $urandom_range(0, 15);
                1:       tot[r] = $urandom_range(0, 300);
                2:       tot[r] = $urandom_range(0, 65535);
                default: tot[r] = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 40);
            endcase
            queue_item(OP_TOTAL, $urandom_range(0, 7), r, tot[r], $urandom_range(0, 65535));
        end
        for (p = 0; p < np; p++) begin
            for (r = 0; r < nr; r++) begin
                share = tot[r] / np;
                // mostly allocations that fit, sometimes enough to overcommit
                a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tot[r])
                                                : $urandom_range(0, share);
                case (cmode)
                    0:       c = $urandom_range(a, tot[r]);
                    1:       c = a + $urandom_range(0, (share < tot[r] - a) ? share : tot[r] - a);
                    default: c = a;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    if (tot[r] < 65535 && $urandom_range(0, 1))
                        queue_item(OP_CLAIM, p, r, $urandom_range(tot[r] + 1, 65535),
                                   $urandom_range(0, 65535));
                    else if (c < 65535)
                        queue_item(OP_CLAIM, p, r, c, $urandom_range(c + 1, 65535));
                end
                if ($urandom_range(0, 11) == 0) begin
                    if (np < N_PROCS && $urandom_range(0, 1))
                        queue_item(OP_CLAIM, $urandom_range(np, N_PROCS - 1), r,
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
                    else
                        queue_item(OP_NOP, $urandom_range(0, 7), $urandom_range(0, 3),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                queue_item(OP_CLAIM, p, r, c, a);
            end
        end
        queue_item(OP_CHECK, $urandom_range(0, 7), $urandom_range(0, 3),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
        // a repeated check must give the same answer from fresh work
        if ($urandom_range(0, 3) == 0)
            queue_item(OP_CHECK, 0, 0, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase, p, r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Every pair gets written up front so no check ever reads an
        // entry that was never loaded. Zero allocation: the first check
        // grants all eight processes in order.
        for (r = 0; r < N_RES; r++) queue_item(OP_TOTAL, 0, r, 65535, 0);
        for (p = 0; p < N_PROCS; p++)
            for (r = 0; r < N_RES; r++)
                queue_item(OP_CLAIM, p, r, $urandom_range(0, 65535), 0);
        queue_item(OP_CHECK, 0, 0, 0, 0);

        // load status codes, claim tested before allocation
        queue_item(OP_TOTAL, 0, 1, 0, 65535);
        queue_item(OP_CLAIM, 7, 1, 1, 0);       // claim over total
        queue_item(OP_CLAIM, 7, 1, 1, 2);       // both wrong: claim wins
        queue_item(OP_TOTAL, 0, 1, 100, 0);
        queue_item(OP_CLAIM, 7, 1, 50, 51);     // alloc over claim
        queue_item(OP_CLAIM, 7, 1, 50, 50);
        queue_item(OP_CLAIM, 3, 1, 60, 60);
        queue_item(OP_CHECK, 7, 3, 65535, 65535); // allocations exceed total
        queue_item(OP_NOP, 7, 3, 65535, 65535);   // dropped, no result
        queue_item(OP_NOP, 0, 0, 0, 0);
        queue_item(OP_CLAIM, 3, 1, 60, 10);     // now p3 waits for p7's release
        queue_item(OP_CHECK, 0, 0, 0, 0);
        queue_item(OP_TOTAL, 0, 2, 5, 0);
        queue_item(OP_CLAIM, 0, 2, 5, 2);
        queue_item(OP_CLAIM, 1, 2, 5, 2);
        queue_item(OP_CHECK, 0, 0, 0, 0);       // deadlock on class 2
        wait_idle();

        // random part: one scenario per config setting, extremes first
        count_random = 1'b1;
        phase = 0;
        while (random_items < 150) begin
            case (phase)
                0: begin
                    write_reg(REG_PROCS, 0);    // zero counts as one
                    write_reg(REG_RES, 0);
                end
                1: begin
                    write_reg(REG_PROCS, 15);   // clamps to the build limits
                    write_reg(REG_RES, 7);
                end
                2: begin
                    write_reg(REG_PROCS, 1);
                    write_reg(REG_RES, 1);
                end
                3: begin
                    write_reg(REG_PROCS, 8);
                    write_reg(REG_RES, 4);
                end
                default: begin
                    write_reg(REG_PROCS, $urandom_range(0, 15));
                    write_reg(REG_RES, $urandom_range(0, 7));
                end
            endcase
            queue_scenario();
            wait_idle();
            phase++;
        end

        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rsc_pkg.sv
hw/rtl/rsc_ram.sv
hw/rtl/rsc_alu.sv
hw/rtl/rsc_cfg.sv
hw/rtl/resource_safety_checker_unit.sv
sim/testbench.sv
